// ===== rtl/core/bad_pkg.sv =====
// ----------------------------------------------------------------------------
// bad_pkg
// Shared widths, register indexes, axis mode codes and reset values of the
// block average downscaler.
// ----------------------------------------------------------------------------
package bad_pkg;

	localparam int PIX_W      = 16;
	localparam int FACTOR_W   = 5;
	localparam int AXIS_W     = 2;
	localparam int DIM_W      = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_FACTOR = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FACTOR = 3'd0,
		REG_AXIS   = 3'd1,
		REG_AVG    = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} cfg_reg_t;

	localparam logic [AXIS_W-1:0] MODE_X  = 2'd0;
	localparam logic [AXIS_W-1:0] MODE_Y  = 2'd1;
	localparam logic [AXIS_W-1:0] MODE_XY = 2'd2;

	localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd2;
	localparam logic [AXIS_W-1:0]   RST_AXIS   = MODE_XY;
	localparam logic                RST_AVG    = 1'b1;
	localparam logic [DIM_W-1:0]    RST_DIM    = 11'd1024;

endpackage

// ===== rtl/core/bad_recalc.sv =====
// ----------------------------------------------------------------------------
// bad_recalc
// Restoring divider, one bit a cycle, that rebuilds the in-block column and
// row offsets and the block column from the position counters.
// ----------------------------------------------------------------------------
module bad_recalc #(
	parameter int COL_W = 10,
	parameter int ROW_W = 10,
	parameter int DIV_W = 5,
	parameter int REM_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] divisor,
	input  logic [COL_W-1:0] col,
	input  logic [ROW_W-1:0] row,
	output logic             busy,
	output logic             done,
	output logic [REM_W-1:0] col_rem,
	output logic [COL_W-1:0] col_quo,
	output logic [REM_W-1:0] row_rem
);

	localparam int NW    = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    cdiv_q, rdiv_q, cquo_q;
	logic [DIV_W-1:0] crem_q, rrem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DIV_W:0]   ctry, rtry;
	logic             cge, rge;
	logic [DIV_W:0]   csub, rsub;

	assign ctry = {crem_q, cdiv_q[NW-1]};
	assign rtry = {rrem_q, rdiv_q[NW-1]};
	assign cge  = ctry >= {1'b0, divisor};
	assign rge  = rtry >= {1'b0, divisor};
	assign csub = ctry - {1'b0, divisor};
	assign rsub = rtry - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cdiv_q <= NW'(col);
			rdiv_q <= NW'(row);
			crem_q <= '0;
			rrem_q <= '0;
			cquo_q <= '0;
		end else if (busy_q) begin
			cdiv_q <= cdiv_q << 1;
			rdiv_q <= rdiv_q << 1;
			crem_q <= cge ? csub[DIV_W-1:0] : ctry[DIV_W-1:0];
			rrem_q <= rge ? rsub[DIV_W-1:0] : rtry[DIV_W-1:0];
			cquo_q <= {cquo_q[NW-2:0], cge};
		end
	end

	assign busy    = busy_q | done_q;
	assign done    = done_q;
	assign col_rem = crem_q[REM_W-1:0];
	assign row_rem = rrem_q[REM_W-1:0];
	assign col_quo = cquo_q[COL_W-1:0];

endmodule

// ===== rtl/core/bad_qdiv.sv =====
// ----------------------------------------------------------------------------
// bad_qdiv
// Divides a block sum by a small count (1 to MAX_FACTOR) through a multiply
// by a rounded-up reciprocal; the product is registered, the shift follows.
// ----------------------------------------------------------------------------
module bad_qdiv #(
	parameter int MAX_FACTOR = 16,
	parameter int SUM_W      = 20
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [SUM_W-1:0]              dividend,
	input  logic [$clog2(MAX_FACTOR)-1:0] dsel,
	output logic [SUM_W-1:0]              quot
);

	localparam int FW  = $clog2(MAX_FACTOR);
	localparam int K   = SUM_W + FW;
	localparam int RCW = K + 1;
	localparam int PW  = SUM_W + RCW;

	logic [RCW-1:0] recip [MAX_FACTOR];
	logic [PW-1:0]  prod_c;
	logic [PW-1:0]  prod_s1;

	for (genvar g = 0; g < MAX_FACTOR; g++) begin : g_recip
		localparam logic [RCW-1:0] RV =
			RCW'(((64'd1 << K) + 64'(g)) / 64'(g + 1));
		assign recip[g] = RV;
	end

	assign prod_c = dividend * recip[dsel];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
		end
	end

	assign quot = prod_s1[K +: SUM_W];

endmodule

// ===== rtl/core/block_average_downscaler_top.sv =====
// ----------------------------------------------------------------------------
// block_average_downscaler_top
// Streaming box-filter decimator: shrinks a raster image by an integer factor
// along X, Y or both, averaging or subsampling each block.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/pixel_value) takes one pixel word in
//   raster order. Output channel (out_valid/out_ready) gives one word per
//   completed block with row_end and frame_end flags. The config channel
//   (cfg_valid/cfg_ready, cfg_index, cfg_data) writes factor, axis_mode,
//   average_enable, image_width and image_height; cfg_ready is always high.
//   One pixel is worked on at a time. A pixel that closes no block goes
//   through S_RD back to S_IDLE, in XY average mode through S_MUL and S_QUO
//   as well when it ends a row segment of a block. A block result goes
//   through S_RD and S_OUT in subsample mode, adds S_MUL and S_QUO with one
//   division and runs them twice in XY average mode (two divisions through
//   the shared reciprocal multiplier); the next pixel can be taken once the
//   word is loaded into the output register. Column sums live in a
//   MAX_WIDTH-entry memory read at acceptance and written back before the
//   next pixel. A factor write starts a bit-serial offset rebuild during
//   which in_ready is low. Reset restores the register defaults and the
//   position counters; the memory is not cleared. When out_ready is low the
//   finished word is held and pixels are still taken up to the next result.
// ----------------------------------------------------------------------------
module block_average_downscaler_top
	import bad_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      out_value,
	output logic                  row_end,
	output logic                  frame_end
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int HW  = $clog2(MAX_HEIGHT);
	localparam int FW  = $clog2(MAX_FACTOR);
	localparam int FW1 = $clog2(MAX_FACTOR + 1);
	localparam int SW  = PIX_W + FW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_MUL  = 5'b00100,
		S_QUO  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[SW] ? {SW{1'b1}} : t[SW-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] sat_pix(input logic [SW-1:0] v);
		return (|v[SW-1:PIX_W]) ? {PIX_W{1'b1}} : v[PIX_W-1:0];
	endfunction

	// configuration
	logic [FACTOR_W-1:0] factor_q;
	logic [AXIS_W-1:0]   axis_q;
	logic                avg_q;
	logic [DIM_W-1:0]    width_q, height_q;

	// position state
	logic [CW-1:0] col_q, bx_q;
	logic [HW-1:0] row_q;
	logic [FW-1:0] cx_q, ry_q;
	logic [SW-1:0] row_sum_q;
	state_t        st_q, st_d;

	// per-pixel work registers
	logic [PIX_W-1:0] pix_q;
	logic [FW-1:0]    icx_q, iry_q, dsel_q;
	logic             iend_x_q, iend_y_q, ilast_c_q, ilast_r_q;
	logic [CW-1:0]    addr_q;
	logic [SW-1:0]    mem_rd_q, acc_q;
	logic             second_q;
	logic [PIX_W-1:0] val_q;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] out_value_q;
	logic             row_end_q, frame_end_q;

	logic [SW-1:0] colsum_mem [MAX_WIDTH];

	logic [FW-1:0]  fm1;
	logic [CW-1:0]  wm1;
	logic [HW-1:0]  hm1;
	logic           is_x, is_y, is_xy;
	logic           last_c, last_r, end_x, end_y;
	logic [CW-1:0]  raddr;
	logic           in_acc, cfg_acc, out_load;
	logic [SW-1:0]  pix_ext, row_new, col_new, smp, acc_c, comb_c, quot;
	logic           rd_go;
	logic           mem_we;
	logic [SW-1:0]  mem_wd;
	logic           qd_en;
	logic           rc_busy, rc_done;
	logic [FW-1:0]  rc_cx, rc_ry;
	logic [CW-1:0]  rc_bx;

	assign fm1 = (factor_q == '0) ? '0 :
		(32'(factor_q) > MAX_FACTOR) ? FW'(MAX_FACTOR - 1) : FW'(factor_q - 1'b1);
	assign wm1 = (width_q == '0) ? '0 :
		(32'(width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : CW'(width_q - 1'b1);
	assign hm1 = (height_q == '0) ? '0 :
		(32'(height_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT - 1) : HW'(height_q - 1'b1);

	assign is_x  = axis_q == MODE_X;
	assign is_y  = axis_q == MODE_Y;
	assign is_xy = !is_x && !is_y;

	assign last_c = col_q >= wm1;
	assign last_r = row_q >= hm1;
	assign end_x  = (cx_q == fm1) || last_c;
	assign end_y  = (ry_q == fm1) || last_r;
	assign raddr  = is_y ? col_q : bx_q;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_ready  = (st_q == S_IDLE) && !rc_busy && !cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (st_q == S_OUT) && (!out_valid_q || out_ready);

	assign pix_ext = SW'(pix_q);
	assign row_new = (icx_q == '0) ? pix_ext :
		(avg_q ? sat_add(row_sum_q, pix_ext) : row_sum_q);
	assign col_new = (iry_q == '0) ? pix_ext :
		(avg_q ? sat_add(mem_rd_q, pix_ext) : mem_rd_q);
	assign smp     = ((icx_q == '0) && (iry_q == '0)) ? pix_ext : mem_rd_q;
	assign acc_c   = is_y ? col_new : ((is_x || avg_q) ? row_new : smp);
	assign comb_c  = (iry_q == '0) ? quot : sat_add(mem_rd_q, quot);
	assign rd_go   = is_x ? iend_x_q :
		is_y ? iend_y_q :
		avg_q ? iend_x_q : (iend_x_q && iend_y_q);

	always_comb begin
		st_d   = st_q;
		mem_we = 1'b0;
		mem_wd = comb_c;
		qd_en  = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				if (in_acc) st_d = S_RD;
			end
			S_RD: begin
				mem_we = is_y || (is_xy && !avg_q && (icx_q == '0) && (iry_q == '0));
				mem_wd = is_y ? col_new : pix_ext;
				if (!rd_go) st_d = S_IDLE;
				else if (avg_q) st_d = S_MUL;
				else st_d = S_OUT;
			end
			S_MUL: begin
				qd_en = 1'b1;
				st_d  = S_QUO;
			end
			S_QUO: begin
				if (!second_q) begin
					mem_we = 1'b1;
					st_d   = iend_y_q ? S_MUL : S_IDLE;
				end else begin
					st_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_load) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q    <= RST_FACTOR;
			axis_q      <= RST_AXIS;
			avg_q       <= RST_AVG;
			width_q     <= RST_DIM;
			height_q    <= RST_DIM;
			st_q        <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			cx_q        <= '0;
			ry_q        <= '0;
			bx_q        <= '0;
			row_sum_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_FACTOR: factor_q <= cfg_data[FACTOR_W-1:0];
					REG_AXIS:   axis_q   <= cfg_data[AXIS_W-1:0];
					REG_AVG:    avg_q    <= cfg_data[0];
					REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			if (rc_done) begin
				cx_q <= rc_cx;
				ry_q <= rc_ry;
				bx_q <= rc_bx;
			end else if (in_acc) begin
				if (last_c) begin
					col_q <= '0;
					cx_q  <= '0;
					bx_q  <= '0;
					if (last_r) begin
						row_q <= '0;
						ry_q  <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						ry_q  <= (ry_q == fm1) ? '0 : ry_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
					cx_q  <= (cx_q == fm1) ? '0 : cx_q + 1'b1;
					if (cx_q == fm1) bx_q <= bx_q + 1'b1;
				end
			end
			if ((st_q == S_RD) && (is_x || (is_xy && avg_q))) row_sum_q <= row_new;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q     <= pixel_value;
			icx_q     <= cx_q;
			iry_q     <= ry_q;
			iend_x_q  <= end_x;
			iend_y_q  <= end_y;
			ilast_c_q <= last_c;
			ilast_r_q <= last_r;
			addr_q    <= raddr;
		end
		if (st_q == S_RD) begin
			acc_q    <= acc_c;
			val_q    <= sat_pix(acc_c);
			dsel_q   <= is_y ? iry_q : icx_q;
			second_q <= !is_xy;
		end
		if (st_q == S_QUO) begin
			if (!second_q) begin
				acc_q    <= comb_c;
				dsel_q   <= iry_q;
				second_q <= 1'b1;
			end else begin
				val_q <= sat_pix(quot);
			end
		end
		if (out_load) begin
			out_value_q <= val_q;
			row_end_q   <= ilast_c_q;
			frame_end_q <= ilast_c_q && ilast_r_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) mem_rd_q <= colsum_mem[raddr];
		if (mem_we) colsum_mem[addr_q] <= mem_wd;
	end

	bad_qdiv #(
		.MAX_FACTOR(MAX_FACTOR),
		.SUM_W     (SW)
	) u_qdiv (
		.clk     (clk),
		.en      (qd_en),
		.dividend(acc_q),
		.dsel    (dsel_q),
		.quot    (quot)
	);

	bad_recalc #(
		.COL_W(CW),
		.ROW_W(HW),
		.DIV_W(FW1),
		.REM_W(FW)
	) u_recalc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_acc && (cfg_index == REG_FACTOR)),
		.divisor(FW1'(fm1) + 1'b1),
		.col    (col_q),
		.row    (row_q),
		.busy   (rc_busy),
		.done   (rc_done),
		.col_rem(rc_cx),
		.col_quo(rc_bx),
		.row_rem(rc_ry)
	);

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule

// ===== rtl/core/bad_checker.sv =====
// ----------------------------------------------------------------------------
// bad_checker
// Port-level checks of the block average downscaler, bound to its top level.
// ----------------------------------------------------------------------------
module bad_checker
	import bad_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [PIX_W-1:0]     out_value,
	input logic                 row_end,
	input logic                 frame_end
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(out_value) && $stable(row_end) && $stable(frame_end)))
		else $error("output word changed while stalled");

	// drop ready after taking a pixel
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("pixel taken while previous one still in work");

	// hold off input while offsets are rebuilt
	a_factor_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_FACTOR)) |=> !in_ready)
		else $error("pixel taken during offset rebuild");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> row_end)
		else $error("frame end without row end");

endmodule

bind block_average_downscaler_top bad_checker u_bad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_index(cfg_index),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_value(out_value),
	.row_end  (row_end),
	.frame_end(frame_end)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_average_downscaler_top. A short table of
// directed pixels and register writes (saturated and zero settings, the
// spare axis code, subsample and partial blocks, an oversized XY mean after
// a mid-image factor change) is followed by a full-width priming row and by
// random phases of register writes and pixel bursts. Every block word is
// predicted in the bench and compared in order; both channels stall at
// random, and the output side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
	import bad_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN        = 10;
	localparam int LONG_HOLD    = 300;
	localparam int RAND_ITEMS   = 1000;
	localparam int QUIET_AFTER  = 800;
	localparam int LIMIT        = 800000;
	localparam int DUE_DEPTH    = 16;

	localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             row_end;
		logic             frame_end;
	} block_word_t;

	typedef enum bit {ROW_CFG, ROW_PIX} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [PIX_W-1:0]      pix;
		bit                    typed;
		block_word_t           want;
	} plan_row_t;

	localparam plan_row_t PLAN [48] = '{
		'{ROW_CFG, REG_FACTOR, 11'd1,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_AXIS,   CFG_DATA_W'(MODE_X),   16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_AVG,    11'd1,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_WIDTH,  11'd1,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_HEIGHT, 11'd1,    16'h0000, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b1}},
		'{ROW_CFG, REG_FACTOR, 11'd0,    16'h0000, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h8001, 1'b1, '{16'h8001, 1'b1, 1'b1}},
		'{ROW_CFG, REG_AXIS,   CFG_DATA_W'(AXIS_SPARE), 16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_WIDTH,  11'd0,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_HEIGHT, 11'd0,    16'h0000, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h1234, 1'b1, '{16'h1234, 1'b1, 1'b1}},
		'{ROW_CFG, REG_FACTOR, 11'd31,   16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_AXIS,   CFG_DATA_W'(MODE_X),   16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_WIDTH,  11'd3,    16'h0000, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFE, 1'b1, '{16'hFFFE, 1'b1, 1'b1}},
		'{ROW_CFG, REG_FACTOR, 11'd2,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_AXIS,   CFG_DATA_W'(MODE_XY),  16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_AVG,    11'd0,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_HEIGHT, 11'd2,    16'h0000, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h0F0F, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hAAAA, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h5555, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h1111, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hF0F0, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h2222, 1'b0, '0},
		'{ROW_CFG, REG_AXIS,   CFG_DATA_W'(MODE_Y),   16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_AVG,    11'd1,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_WIDTH,  11'd2,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_HEIGHT, 11'd3,    16'h0000, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h0001, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h0003, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h7FFF, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'h8000, 1'b0, '0},
		'{ROW_CFG, REG_AXIS,   CFG_DATA_W'(MODE_XY),  16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_FACTOR, 11'd4,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_WIDTH,  11'd1,    16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_HEIGHT, 11'd16,   16'h0000, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b0, '0},
		'{ROW_CFG, REG_FACTOR, 11'd2,    16'h0000, 1'b0, '0},
		'{ROW_PIX, REG_FACTOR, 11'd0,    16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b0}}
	};

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel_value = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [PIX_W-1:0]      out_value;
	logic                  row_end;
	logic                  frame_end;

	// bench copy of the registers and the downscaler state
	logic [FACTOR_W-1:0] cfg_factor = RST_FACTOR;
	logic [AXIS_W-1:0]   cfg_axis   = RST_AXIS;
	logic                cfg_avg    = RST_AVG;
	logic [DIM_W-1:0]    cfg_width  = RST_DIM;
	logic [DIM_W-1:0]    cfg_height = RST_DIM;
	int unsigned         col_acc [DEF_MAX_WIDTH];
	int unsigned         row_acc = 0;
	int unsigned         col_pos = 0;
	int unsigned         row_pos = 0;

	// words still due on the output, oldest at due_rd
	block_word_t due_ring [DUE_DEPTH];
	int unsigned due_wr = 0;
	int unsigned due_rd = 0;
	block_word_t got_w, want_w;
	int unsigned errors     = 0;
	int unsigned words_seen = 0;
	int unsigned pixels_in  = 0;
	int unsigned cycles     = 0;
	int unsigned gap_rate   = 2;
	int unsigned stall_rate = 2;
	bit          hold_out   = 1'b0;

	block_average_downscaler_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.row_end     (row_end),
		.frame_end   (frame_end)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) cycles++;

	function automatic int unsigned lim(input int unsigned v, input int unsigned hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic int unsigned slot_of(input int unsigned i);
		return (i < DEF_MAX_WIDTH) ? i : DEF_MAX_WIDTH - 1;
	endfunction

	task automatic expect_word(input block_word_t word);
		due_ring[due_wr % DUE_DEPTH] = word;
		due_wr++;
	endtask

	task automatic fold_pixel(input logic [PIX_W-1:0] pix, output bit emit,
			output block_word_t word);
		int unsigned f, w, h, cx, ry, s, val, mean, pv;
		logic [AXIS_W-1:0] m;
		bit avg, last_c, last_r, end_x, end_y;
		pv = 32'(pix);
		f = lim(32'(cfg_factor), DEF_MAX_FACTOR);
		w = lim(32'(cfg_width), DEF_MAX_WIDTH);
		h = lim(32'(cfg_height), DEF_MAX_HEIGHT);
		m = (cfg_axis == AXIS_SPARE) ? MODE_XY : cfg_axis;
		avg = cfg_avg;
		cx = col_pos % f;
		ry = row_pos % f;
		last_c = col_pos >= w - 1;
		last_r = row_pos >= h - 1;
		end_x = (cx == f - 1) || last_c;
		end_y = (ry == f - 1) || last_r;
		emit = 1'b0;
		val = 0;
		case (m)
		MODE_X: begin
			if (cx == 0) row_acc = pv;
			else if (avg) row_acc += pv;
			if (end_x) begin
				emit = 1'b1;
				val = avg ? row_acc / (cx + 1) : row_acc;
			end
		end
		MODE_Y: begin
			s = slot_of(col_pos);
			if (ry == 0) col_acc[s] = pv;
			else if (avg) col_acc[s] += pv;
			if (end_y) begin
				emit = 1'b1;
				val = avg ? col_acc[s] / (ry + 1) : col_acc[s];
			end
		end
		default: begin
			s = slot_of(col_pos / f);
			if (avg) begin
				if (cx == 0) row_acc = pv;
				else row_acc += pv;
				if (end_x) begin
					mean = row_acc / (cx + 1);
					if (ry == 0) col_acc[s] = mean;
					else col_acc[s] += mean;
					if (end_y) begin
						emit = 1'b1;
						val = col_acc[s] / (ry + 1);
					end
				end
			end else begin
				if (cx == 0 && ry == 0) col_acc[s] = pv;
				if (end_x && end_y) begin
					emit = 1'b1;
					val = col_acc[s];
				end
			end
		end
		endcase
		word.value = (val > 32'hFFFF) ? 16'hFFFF : 16'(val);
		word.row_end = last_c;
		word.frame_end = last_c && last_r;
		if (last_c) begin
			col_pos = 0;
			row_pos = last_r ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
		REG_FACTOR: cfg_factor = data[FACTOR_W-1:0];
		REG_AXIS:   cfg_axis = data[AXIS_W-1:0];
		REG_AVG:    cfg_avg = data[0];
		REG_WIDTH:  cfg_width = data[DIM_W-1:0];
		REG_HEIGHT: cfg_height = data[DIM_W-1:0];
		default: ;
		endcase
	endtask

	// drop both valids, wait for every block word, then let stray pixels finish
	task automatic settle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (due_wr != due_rd) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic offer_pixel(input logic [PIX_W-1:0] pix);
		int unsigned n;
		cfg_valid <= 1'b0;
		if (gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
			in_valid <= 1'b0;
			n = $urandom_range(1, 14);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= pix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pixels_in++;
	endtask

	task automatic push_pixel(input logic [PIX_W-1:0] pix);
		bit emit;
		block_word_t word;
		offer_pixel(pix);
		fold_pixel(pix, emit, word);
		if (emit) expect_word(word);
	endtask

	initial begin
		int unsigned n;
		wait (arst_n);
		forever begin
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_out = 1'b0;
			end else if (stall_rate != 0 && $urandom_range(0, 7) < stall_rate) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 14);
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_w = '{out_value, row_end, frame_end};
			if (due_wr == due_rd) begin
				errors++;
				$display("%0t: expected no word, got %h re %b fe %b",
					$time, got_w.value, got_w.row_end, got_w.frame_end);
			end else begin
				want_w = due_ring[due_rd % DUE_DEPTH];
				due_rd++;
				words_seen++;
				if (got_w !== want_w) begin
					errors++;
					$display("%0t: expected %h re %b fe %b, got %h re %b fe %b",
						$time, want_w.value, want_w.row_end, want_w.frame_end,
						got_w.value, got_w.row_end, got_w.frame_end);
				end
			end
		end
	end

	initial begin
		wait (cycles >= LIMIT);
		$display("block_average_downscaler_top test failed");
		$finish;
	end

	initial begin
		bit emit;
		bit late;
		block_word_t word;
		int unsigned n, nw, rand_items, phase;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		logic [PIX_W-1:0] p;
		rand_items = 0;
		phase = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG) begin
				settle();
				write_reg(PLAN[i].idx, PLAN[i].data);
			end else begin
				offer_pixel(PLAN[i].pix);
				fold_pixel(PLAN[i].pix, emit, word);
				if (PLAN[i].typed) expect_word(PLAN[i].want);
				else if (emit) expect_word(word);
			end
		end

		// one full-width row in Y mode writes every column sum
		settle();
		write_reg(REG_AXIS, CFG_DATA_W'(MODE_Y));
		write_reg(REG_FACTOR, 11'd1);
		write_reg(REG_AVG, CFG_DATA_W'($urandom()));
		write_reg(REG_WIDTH, CFG_DATA_W'(DEF_MAX_WIDTH));
		write_reg(REG_HEIGHT, 11'd1);
		repeat (DEF_MAX_WIDTH) push_pixel(PIX_W'($urandom()));

		while (rand_items < RAND_ITEMS) begin
			settle();
			late = rand_items >= QUIET_AFTER;
			gap_rate = late ? 0 : $urandom_range(0, 4);
			stall_rate = late ? 0 : $urandom_range(0, 4);
			nw = $urandom_range(1, 4);
			repeat (nw) begin
				if ($urandom_range(0, 11) == 0) idx = CFG_IDX_W'($urandom());
				else idx = CFG_IDX_W'($urandom_range(REG_FACTOR, REG_HEIGHT));
				case (idx)
				REG_FACTOR: begin
					case ($urandom_range(0, 9))
					0: data = '0;
					1: data = CFG_DATA_W'(DEF_MAX_FACTOR);
					2: data = CFG_DATA_W'($urandom_range(DEF_MAX_FACTOR + 1, 31));
					3: data = CFG_DATA_W'($urandom());
					default: data = CFG_DATA_W'($urandom_range(1, 8));
					endcase
				end
				REG_WIDTH, REG_HEIGHT: begin
					case ($urandom_range(0, 9))
					0: data = '0;
					1: data = CFG_DATA_W'(DEF_MAX_WIDTH);
					2: data = CFG_DATA_W'($urandom_range(DEF_MAX_WIDTH + 1, 2047));
					3: data = CFG_DATA_W'($urandom_range(41, DEF_MAX_WIDTH - 1));
					4: data = 11'd1;
					default: data = CFG_DATA_W'($urandom_range(2, 40));
					endcase
				end
				default: data = CFG_DATA_W'($urandom());
				endcase
				write_reg(idx, data);
			end
			n = $urandom_range(1, 120);
			if (!late && phase % 8 == 3) begin
				hold_out = 1'b1;
				n = 100;
			end
			repeat (n) begin
				case ($urandom_range(0, 9))
				0: p = '0;
				1: p = '1;
				default: p = PIX_W'($urandom());
				endcase
				push_pixel(p);
			end
			rand_items += n;
			phase++;
		end

		settle();
		$display("Run covered %0d pixels in %0d random phases after the directed table.",
			pixels_in, phase);
		$display("%0d block words compared, %0d mismatches.", words_seen, errors);
		if (errors == 0 && due_wr == due_rd) begin
			$display("block_average_downscaler_top test passed");
		end else begin
			$display("block_average_downscaler_top test failed");
		end
		$finish;
	end

endmodule
